### hw/rtl/gctm_pkg.sv
// Shared types and constants for the greedy cluster track matcher.
`default_nettype none
package gctm_pkg;
    localparam int COORD_W  = 20;
    localparam int POS_W    = 3 * COORD_W;
    localparam int MAG_W    = 20;
    localparam int DIST_W   = 42;
    localparam int THRESH_W = 44;
    localparam int TRACK_W  = 32;
    localparam int CIDX_W   = 5;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 44'd25000000;

    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } pos_t;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    typedef struct packed {
        logic  clear;
        logic  diff;
        logic  mac;
        axis_t axis;
    } dist_ctrl_t;
endpackage
`default_nettype wire

### hw/rtl/greedy_cluster_track_matcher_core.sv
// Greedy nearest-neighbor cluster track matcher, top level.
// Non-final item: accepted only while idle. Final item: each matching pass scans all
// (current, previous) pairs, each open pair taking S_DIFF/S_MAC per axis in the shared
// distance unit, up to min(cur, prev)+1 passes; each result is then held while result_stall.
// Reset: control cleared, threshold 25000000, ID counter 1, no history; memories not cleared.
`default_nettype none
module greedy_cluster_track_matcher_core #(
    parameter int MAX_CLUSTERS = 32,
    parameter int ID_BITS      = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              write_enable,
    input  wire logic [gctm_pkg::THRESH_W-1:0]     write_data,
    input  wire logic                              valid,
    output logic                                   stall,
    input  wire logic signed [gctm_pkg::COORD_W-1:0] pos_x,
    input  wire logic signed [gctm_pkg::COORD_W-1:0] pos_y,
    input  wire logic signed [gctm_pkg::COORD_W-1:0] pos_z,
    input  wire logic                              frame_end,
    output logic                                   result_valid,
    input  wire logic                              result_stall,
    output logic [gctm_pkg::CIDX_W-1:0]            cluster_index,
    output logic [gctm_pkg::TRACK_W-1:0]           track_id,
    output logic                                   is_new,
    output logic                                   frame_overflow,
    output logic                                   last_result
);
    localparam int IDX_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int CNT_W = $clog2(MAX_CLUSTERS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CLUSTERS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DIFF,
        S_MAC,
        S_CMP,
        S_PASS,
        S_OREAD,
        S_OLOAD,
        S_OWAIT
    } state_t;

    state_t                          state_reg;
    logic [gctm_pkg::THRESH_W-1:0]   thresh_reg;
    logic                            bank_reg;
    logic [CNT_W-1:0]                cur_count_reg;
    logic [CNT_W-1:0]                prev_count_reg;
    logic [MAX_CLUSTERS-1:0]         cur_matched_reg;
    logic [MAX_CLUSTERS-1:0]         prev_matched_reg;
    logic [IDX_W-1:0]                match_idx_reg [MAX_CLUSTERS];
    logic [ID_BITS-1:0]              next_id_reg;
    logic                            overflow_reg;
    logic [CNT_W-1:0]                c_reg;
    logic [CNT_W-1:0]                p_reg;
    logic [CNT_W-1:0]                i_reg;
    gctm_pkg::axis_t                 axis_reg;
    logic                            found_reg;
    logic [gctm_pkg::DIST_W-1:0]     best_reg;
    logic [IDX_W-1:0]                bc_reg;
    logic [IDX_W-1:0]                bp_reg;
    logic                            result_valid_reg;
    logic [gctm_pkg::CIDX_W-1:0]     cluster_index_reg;
    logic [gctm_pkg::TRACK_W-1:0]    track_id_reg;
    logic                            is_new_reg;
    logic                            frame_overflow_reg;
    logic                            last_result_reg;

    logic [ID_BITS-1:0]              id_mem [2][MAX_CLUSTERS];
    logic [ID_BITS-1:0]              id_rd_reg;

    logic                            accept;
    logic                            store;
    logic [IDX_W-1:0]                c_idx;
    logic [IDX_W-1:0]                p_idx;
    logic [IDX_W-1:0]                i_idx;
    logic                            i_matched;
    logic [ID_BITS-1:0]              id_sel;
    logic [ID_BITS-1:0]              id_inc;
    logic [ID_BITS-1:0]              next_id_next;
    gctm_pkg::pos_t                  in_pos;
    gctm_pkg::pos_t                  cur_pos;
    gctm_pkg::pos_t                  prev_pos;
    gctm_pkg::dist_ctrl_t            dctrl;
    logic [gctm_pkg::DIST_W-1:0]     dist_sum;

    assign stall  = (state_reg != S_IDLE);
    assign accept = valid && !stall;
    assign store  = accept && (cur_count_reg < CNT_MAX);
    assign c_idx  = c_reg[IDX_W-1:0];
    assign p_idx  = p_reg[IDX_W-1:0];
    assign i_idx  = i_reg[IDX_W-1:0];
    assign in_pos = '{z: pos_z, y: pos_y, x: pos_x};

    assign i_matched = cur_matched_reg[i_idx];
    assign id_sel    = i_matched ? id_rd_reg : next_id_reg;
    assign id_inc    = next_id_reg + ID_BITS'(1);
    // counter wraps past zero back to one
    assign next_id_next = (id_inc == '0) ? ID_BITS'(1) : id_inc;

    always_comb
    begin
        dctrl.clear = (state_reg == S_SCAN);
        dctrl.diff  = (state_reg == S_DIFF);
        dctrl.mac   = (state_reg == S_MAC);
        dctrl.axis  = axis_reg;
    end

    gctm_pos_mem #(
        .MAX_CLUSTERS(MAX_CLUSTERS),
        .IDX_W(IDX_W)
    ) u_pos_mem (
        .clk(clk),
        .wr_en(store),
        .wr_bank(bank_reg),
        .wr_idx(cur_count_reg[IDX_W-1:0]),
        .wr_data(in_pos),
        .rd_en(state_reg == S_SCAN),
        .cur_bank(bank_reg),
        .cur_idx(c_idx),
        .prev_idx(p_idx),
        .cur_data(cur_pos),
        .prev_data(prev_pos)
    );

    gctm_dist_unit u_dist (
        .clk(clk),
        .ctrl(dctrl),
        .cur_pos(cur_pos),
        .prev_pos(prev_pos),
        .dist_sum(dist_sum)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OREAD)
        begin
            id_rd_reg <= id_mem[~bank_reg][match_idx_reg[i_idx]];
        end
        if (state_reg == S_OLOAD)
        begin
            id_mem[bank_reg][i_idx] <= id_sel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_PASS && found_reg && gctm_pkg::THRESH_W'(best_reg) <= thresh_reg)
        begin
            match_idx_reg[bc_reg] <= bp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            thresh_reg         <= gctm_pkg::THRESH_RESET;
            bank_reg           <= 1'b0;
            cur_count_reg      <= '0;
            prev_count_reg     <= '0;
            cur_matched_reg    <= '0;
            prev_matched_reg   <= '0;
            next_id_reg        <= ID_BITS'(1);
            overflow_reg       <= 1'b0;
            c_reg              <= '0;
            p_reg              <= '0;
            i_reg              <= '0;
            axis_reg           <= gctm_pkg::AXIS_X;
            found_reg          <= 1'b0;
            best_reg           <= '0;
            bc_reg             <= '0;
            bp_reg             <= '0;
            result_valid_reg   <= 1'b0;
            cluster_index_reg  <= '0;
            track_id_reg       <= '0;
            is_new_reg         <= 1'b0;
            frame_overflow_reg <= 1'b0;
            last_result_reg    <= 1'b0;
        end
        else
        begin
            if (write_enable)
            begin
                thresh_reg <= write_data;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (store)
                        begin
                            cur_count_reg <= cur_count_reg + CNT_ONE;
                        end
                        else
                        begin
                            overflow_reg <= 1'b1;
                        end
                        if (frame_end)
                        begin
                            cur_matched_reg  <= '0;
                            prev_matched_reg <= '0;
                            c_reg            <= '0;
                            p_reg            <= '0;
                            i_reg            <= '0;
                            found_reg        <= 1'b0;
                            state_reg        <= (prev_count_reg == '0) ? S_OREAD : S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (c_reg >= cur_count_reg)
                    begin
                        state_reg <= S_PASS;
                    end
                    else if (cur_matched_reg[c_idx] || p_reg >= prev_count_reg)
                    begin
                        c_reg <= c_reg + CNT_ONE;
                        p_reg <= '0;
                    end
                    else if (prev_matched_reg[p_idx])
                    begin
                        p_reg <= p_reg + CNT_ONE;
                    end
                    else
                    begin
                        axis_reg  <= gctm_pkg::AXIS_X;
                        state_reg <= S_DIFF;
                    end
                end
                S_DIFF:
                begin
                    state_reg <= S_MAC;
                end
                S_MAC:
                begin
                    case (axis_reg)
                        gctm_pkg::AXIS_X: axis_reg <= gctm_pkg::AXIS_Y;
                        gctm_pkg::AXIS_Y: axis_reg <= gctm_pkg::AXIS_Z;
                        default:          axis_reg <= gctm_pkg::AXIS_X;
                    endcase
                    state_reg <= (axis_reg == gctm_pkg::AXIS_Z) ? S_CMP : S_DIFF;
                end
                S_CMP:
                begin
                    // strict compare keeps the earliest pair in scan order on ties
                    if (!found_reg || dist_sum < best_reg)
                    begin
                        found_reg <= 1'b1;
                        best_reg  <= dist_sum;
                        bc_reg    <= c_idx;
                        bp_reg    <= p_idx;
                    end
                    p_reg     <= p_reg + CNT_ONE;
                    state_reg <= S_SCAN;
                end
                S_PASS:
                begin
                    c_reg     <= '0;
                    p_reg     <= '0;
                    found_reg <= 1'b0;
                    if (found_reg && gctm_pkg::THRESH_W'(best_reg) <= thresh_reg)
                    begin
                        cur_matched_reg[bc_reg]  <= 1'b1;
                        prev_matched_reg[bp_reg] <= 1'b1;
                        state_reg                <= S_SCAN;
                    end
                    else
                    begin
                        i_reg     <= '0;
                        state_reg <= S_OREAD;
                    end
                end
                S_OREAD:
                begin
                    state_reg <= S_OLOAD;
                end
                S_OLOAD:
                begin
                    result_valid_reg   <= 1'b1;
                    cluster_index_reg  <= gctm_pkg::CIDX_W'(i_reg);
                    track_id_reg       <= gctm_pkg::TRACK_W'(id_sel);
                    is_new_reg         <= !i_matched;
                    frame_overflow_reg <= overflow_reg;
                    last_result_reg    <= (i_reg + CNT_ONE == cur_count_reg);
                    if (!i_matched)
                    begin
                        next_id_reg <= next_id_next;
                    end
                    state_reg <= S_OWAIT;
                end
                S_OWAIT:
                begin
                    if (!result_stall)
                    begin
                        result_valid_reg <= 1'b0;
                        if (last_result_reg)
                        begin
                            bank_reg       <= ~bank_reg;
                            prev_count_reg <= cur_count_reg;
                            cur_count_reg  <= '0;
                            overflow_reg   <= 1'b0;
                            state_reg      <= S_IDLE;
                        end
                        else
                        begin
                            i_reg     <= i_reg + CNT_ONE;
                            state_reg <= S_OREAD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid   = result_valid_reg;
    assign cluster_index  = cluster_index_reg;
    assign track_id       = track_id_reg;
    assign is_new         = is_new_reg;
    assign frame_overflow = frame_overflow_reg;
    assign last_result    = last_result_reg;
endmodule
`default_nettype wire

### hw/rtl/gctm_pos_mem.sv
// Two-bank cluster position memory: one write port, two registered read ports.
`default_nettype none
module gctm_pos_mem #(
    parameter int MAX_CLUSTERS = 32,
    parameter int IDX_W        = 5
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic              wr_bank,
    input  wire logic [IDX_W-1:0]  wr_idx,
    input  wire gctm_pkg::pos_t    wr_data,
    input  wire logic              rd_en,
    input  wire logic              cur_bank,
    input  wire logic [IDX_W-1:0]  cur_idx,
    input  wire logic [IDX_W-1:0]  prev_idx,
    output gctm_pkg::pos_t         cur_data,
    output gctm_pkg::pos_t         prev_data
);
    gctm_pkg::pos_t mem [2][MAX_CLUSTERS];
    gctm_pkg::pos_t cur_data_reg;
    gctm_pkg::pos_t prev_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_bank][wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            cur_data_reg  <= mem[cur_bank][cur_idx];
            prev_data_reg <= mem[~cur_bank][prev_idx];
        end
    end

    assign cur_data  = cur_data_reg;
    assign prev_data = prev_data_reg;
endmodule
`default_nettype wire

### hw/rtl/gctm_dist_unit.sv
// Shared squared-distance unit: one axis difference and one multiply-accumulate a step.
`default_nettype none
module gctm_dist_unit (
    input  wire logic                         clk,
    input  wire gctm_pkg::dist_ctrl_t         ctrl,
    input  wire gctm_pkg::pos_t               cur_pos,
    input  wire gctm_pkg::pos_t               prev_pos,
    output logic [gctm_pkg::DIST_W-1:0]       dist_sum
);
    logic signed [gctm_pkg::COORD_W-1:0] a;
    logic signed [gctm_pkg::COORD_W-1:0] b;
    logic signed [gctm_pkg::COORD_W:0]   d;
    logic [gctm_pkg::COORD_W:0]          d_abs;
    logic [gctm_pkg::MAG_W-1:0]          mag_reg;
    logic [gctm_pkg::MAG_W-1:0]          mag_next;
    logic [2*gctm_pkg::MAG_W-1:0]        sq;
    logic [gctm_pkg::DIST_W-1:0]         acc_reg;

    always_comb
    begin
        case (ctrl.axis)
            gctm_pkg::AXIS_X:
            begin
                a = cur_pos.x;
                b = prev_pos.x;
            end
            gctm_pkg::AXIS_Y:
            begin
                a = cur_pos.y;
                b = prev_pos.y;
            end
            gctm_pkg::AXIS_Z:
            begin
                a = cur_pos.z;
                b = prev_pos.z;
            end
            default:
            begin
                a = cur_pos.x;
                b = prev_pos.x;
            end
        endcase
        d        = {a[gctm_pkg::COORD_W-1], a} - {b[gctm_pkg::COORD_W-1], b};
        d_abs    = d[gctm_pkg::COORD_W] ? (~d + 1'b1) : d;
        mag_next = d_abs[gctm_pkg::MAG_W-1:0];
        sq       = mag_reg * mag_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.diff)
        begin
            mag_reg <= mag_next;
        end
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.mac)
        begin
            acc_reg <= acc_reg + gctm_pkg::DIST_W'(sq);
        end
    end

    assign dist_sum = acc_reg;
endmodule
`default_nettype wire
